// File: rtl/core/ef2d_pkg.sv
// Shared constants and register codes for the 2D Euler flux core.
// No dependencies.
package ef2d_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  localparam int unsigned GAMMA_W = 18;
  localparam int unsigned EPS_W   = 16;
  localparam int unsigned CFG_W   = 18;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
  localparam logic [EPS_W-1:0]   EPS_RESET   = 16'd1;

  typedef enum logic [0:0] {
    REG_GAMMA = 1'b0,
    REG_EPS   = 1'b1
  } cfg_reg_e;

endpackage

// File: rtl/core/euler_flux_2d_core.sv
// 2D Euler flux core: one item per cycle, no stalls on the result side.
// Pipeline: front register, two-entry queue, back stages A and B, the bit-per-stage divider
// pipelines and stages C to F; done_o and the results come from the stage F registers.
// Throughput: one item per cycle; busy never rises while results flow.
// Reset: asynchronous, active low; empties the pipeline, gamma 1.4, epsilon 1 lsb.
// Depends on ef2d_pkg, ef2d_front, ef2d_queue, ef2d_back.
module euler_flux_2d_core #(
  parameter int unsigned DATA_WIDTH = ef2d_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = ef2d_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [ef2d_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic signed [DATA_WIDTH-1:0] density_i,
  input  logic signed [DATA_WIDTH-1:0] momentum_x_i,
  input  logic signed [DATA_WIDTH-1:0] momentum_y_i,
  input  logic signed [DATA_WIDTH-1:0] total_energy_i,
  output logic                        done_o,
  output logic signed [DATA_WIDTH-1:0] fx_mass_o,
  output logic signed [DATA_WIDTH-1:0] fx_mom_x_o,
  output logic signed [DATA_WIDTH-1:0] fx_mom_y_o,
  output logic signed [DATA_WIDTH-1:0] fx_energy_o,
  output logic signed [DATA_WIDTH-1:0] fy_mass_o,
  output logic signed [DATA_WIDTH-1:0] fy_mom_x_o,
  output logic signed [DATA_WIDTH-1:0] fy_mom_y_o,
  output logic signed [DATA_WIDTH-1:0] fy_energy_o,
  output logic                        zero_density_o,
  output logic                        saturated_o
);

  localparam int unsigned DW = 4 * DATA_WIDTH + 1;

  logic [ef2d_pkg::GAMMA_W-1:0] gamma_q;
  logic [ef2d_pkg::EPS_W-1:0]   eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= ef2d_pkg::GAMMA_RESET;
      eps_q   <= ef2d_pkg::EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (ef2d_pkg::cfg_reg_e'(cfg_idx_i))
        ef2d_pkg::REG_GAMMA: gamma_q <= cfg_data_i[ef2d_pkg::GAMMA_W-1:0];
        ef2d_pkg::REG_EPS:   eps_q   <= cfg_data_i[ef2d_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic          fr_valid;
  logic [DW-1:0] fr_data;
  logic          q_full;
  logic          q_valid;
  logic [DW-1:0] q_data;

  assign busy = q_full;

  ef2d_front #(.W(DATA_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (q_full),
    .density_i      (density_i),
    .momentum_x_i   (momentum_x_i),
    .momentum_y_i   (momentum_y_i),
    .total_energy_i (total_energy_i),
    .eps_i          (eps_q),
    .valid_o        (fr_valid),
    .data_o         (fr_data)
  );

  ef2d_queue #(.DW(DW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (fr_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  ef2d_back #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .data_i         (q_data),
    .gamma_i        (gamma_q),
    .done_o         (done_o),
    .fx_mass_o      (fx_mass_o),
    .fx_mom_x_o     (fx_mom_x_o),
    .fx_mom_y_o     (fx_mom_y_o),
    .fx_energy_o    (fx_energy_o),
    .fy_mass_o      (fy_mass_o),
    .fy_mom_x_o     (fy_mom_x_o),
    .fy_mom_y_o     (fy_mom_y_o),
    .fy_energy_o    (fy_energy_o),
    .zero_density_o (zero_density_o),
    .saturated_o    (saturated_o)
  );

endmodule

// File: rtl/core/ef2d_front.sv
// Front end: takes an item, flags degenerate density and registers it.
// Depends on ef2d_pkg.
module ef2d_front #(
  parameter int unsigned W = ef2d_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic signed [W-1:0]        density_i,
  input  logic signed [W-1:0]        momentum_x_i,
  input  logic signed [W-1:0]        momentum_y_i,
  input  logic signed [W-1:0]        total_energy_i,
  input  logic [ef2d_pkg::EPS_W-1:0] eps_i,
  output logic                       valid_o,
  output logic [4*W:0]               data_o
);

  localparam int unsigned CW = W + ef2d_pkg::EPS_W;

  logic          accept;
  logic [W-1:0]  rho_mag;
  logic          degen;
  logic          valid_q;
  logic [4*W:0]  data_q;

  assign accept  = start_i & ~busy_i;
  assign rho_mag = density_i[W-1] ? (~density_i + W'(1)) : density_i;
  assign degen   = (density_i == '0) || (CW'(rho_mag) < CW'(eps_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= {degen, total_energy_i, momentum_y_i, momentum_x_i, density_i};
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/core/ef2d_queue.sv
// Two-entry queue between front and back; the back drains it every cycle.
// Depends on ef2d_pkg.
module ef2d_queue #(
  parameter int unsigned DW = 4 * ef2d_pkg::DATA_WIDTH_DEF + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  output logic          valid_o,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_q;
  logic          rd_q;
  logic [1:0]    cnt_q;
  logic          pop;

  assign pop = (cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_q ^ push_i;
      rd_q  <= rd_q ^ pop;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("item pushed into full queue");
`endif

endmodule

// File: rtl/core/ef2d_div.sv
// Pipelined restoring divider, one quotient bit per stage: (|n| << F) / |d|.
// Depends on ef2d_pkg.
module ef2d_div #(
  parameter int unsigned W = ef2d_pkg::DATA_WIDTH_DEF,
  parameter int unsigned F = ef2d_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic [W+F-1:0]      q_o,
  output logic                neg_o
);

  localparam int unsigned QW = W + F;

  logic [W-1:0]  rem_q [QW];
  logic [QW-1:0] sr_q  [QW];
  logic [W-1:0]  den_q [QW];
  logic          neg_q [QW];
  logic [W-1:0]  num_mag;
  logic [W-1:0]  den_mag;

  assign num_mag = num_i[W-1] ? (~num_i + W'(1)) : num_i;
  assign den_mag = den_i[W-1] ? (~den_i + W'(1)) : den_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [W-1:0]  den_in;
    logic [QW-1:0] sr_in;
    logic          neg_in;
    logic [W:0]    t;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_mag;
      assign sr_in  = {num_mag, {F{1'b0}}};
      assign neg_in = num_i[W-1] ^ den_i[W-1];
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign sr_in  = sr_q[k-1];
      assign neg_in = neg_q[k-1];
    end

    assign t  = {rem_in, sr_in[QW-1]};
    assign ge = (t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? W'(t - {1'b0, den_in}) : t[W-1:0];
      sr_q[k]  <= {sr_in[QW-2:0], ge};
      den_q[k] <= den_in;
      neg_q[k] <= neg_in;
    end
  end

  assign q_o   = sr_q[QW-1];
  assign neg_o = neg_q[QW-1];

endmodule

// File: rtl/core/ef2d_back.sv
// Back end: squares, three pipelined divides, pressure and flux products.
// Depends on ef2d_pkg and ef2d_div.
module ef2d_back #(
  parameter int unsigned W = ef2d_pkg::DATA_WIDTH_DEF,
  parameter int unsigned F = ef2d_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [4*W:0]                 data_i,
  input  logic [ef2d_pkg::GAMMA_W-1:0] gamma_i,
  output logic                         done_o,
  output logic signed [W-1:0]          fx_mass_o,
  output logic signed [W-1:0]          fx_mom_x_o,
  output logic signed [W-1:0]          fx_mom_y_o,
  output logic signed [W-1:0]          fx_energy_o,
  output logic signed [W-1:0]          fy_mass_o,
  output logic signed [W-1:0]          fy_mom_x_o,
  output logic signed [W-1:0]          fy_mom_y_o,
  output logic signed [W-1:0]          fy_energy_o,
  output logic                         zero_density_o,
  output logic                         saturated_o
);

  localparam int unsigned QW = W + F;
  localparam int unsigned GW =
    ((ef2d_pkg::GAMMA_W > F) ? ef2d_pkg::GAMMA_W : F) + 2;
  localparam int unsigned MW = GW + 2 * W + F;
  localparam int unsigned SW = 3 * W + 2;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // {flag, value}: magnitude with sign back to W bits, clamped
  function automatic logic [W:0] sat_mag(input logic neg, input logic [MW-1:0] m);
    logic [MW-1:0] lim;
    logic [W-1:0]  lo;
    lim = MW'(1) << (W - 1);
    lo  = m[W-1:0];
    if (!neg && (m > lim - MW'(1))) begin
      sat_mag = {1'b1, 1'b0, {(W-1){1'b1}}};
    end else if (neg && (m > lim)) begin
      sat_mag = {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      sat_mag = {1'b0, neg ? (~lo + W'(1)) : lo};
    end
  endfunction

  function automatic logic [W:0] clamp1(input logic [W:0] s);
    if (s[W] != s[W-1]) begin
      clamp1 = {1'b1, s[W], {(W-1){~s[W]}}};
    end else begin
      clamp1 = {1'b0, s[W-1:0]};
    end
  endfunction

  function automatic logic [W:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b);
    sadd = clamp1({a[W-1], a} + {b[W-1], b});
  endfunction

  function automatic logic [W:0] ssub(input logic [W-1:0] a, input logic [W-1:0] b);
    ssub = clamp1({a[W-1], a} - {b[W-1], b});
  endfunction

  function automatic logic [W:0] fmul(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [2*W-1:0] pr;
    pr   = (2*W)'(mag(a)) * (2*W)'(mag(b));
    fmul = sat_mag(a[W-1] ^ b[W-1], MW'(pr >> F));
  endfunction

  // stage A: squares
  logic         vld_a_q, dg_a_q;
  logic [W-1:0] rho_a_q, mx_a_q, my_a_q, e_a_q, xx_a_q, yy_a_q;
  logic         sat_a_q;
  logic [W:0]   r_xx, r_yy;

  assign r_xx = fmul(data_i[2*W-1:W], data_i[2*W-1:W]);
  assign r_yy = fmul(data_i[3*W-1:2*W], data_i[3*W-1:2*W]);

  // stage B: kinetic sum, divider feed
  logic         vld_b_q, dg_b_q, sat_b_q;
  logic [W-1:0] rho_b_q, mx_b_q, my_b_q, e_b_q, sq_b_q;
  logic [W:0]   r_sq;

  assign r_sq = sadd(xx_a_q, yy_a_q);

  always_ff @(posedge clk_i) begin
    rho_a_q <= data_i[W-1:0];
    mx_a_q  <= data_i[2*W-1:W];
    my_a_q  <= data_i[3*W-1:2*W];
    e_a_q   <= data_i[4*W-1:3*W];
    dg_a_q  <= data_i[4*W];
    xx_a_q  <= r_xx[W-1:0];
    yy_a_q  <= r_yy[W-1:0];
    sat_a_q <= r_xx[W] | r_yy[W];
    rho_b_q <= rho_a_q;
    mx_b_q  <= mx_a_q;
    my_b_q  <= my_a_q;
    e_b_q   <= e_a_q;
    dg_b_q  <= dg_a_q;
    sq_b_q  <= r_sq[W-1:0];
    sat_b_q <= sat_a_q | r_sq[W];
  end

  logic [QW-1:0] ke_q, u_q, v_q;
  logic          ke_neg, u_neg, v_neg;

  ef2d_div #(.W(W), .F(F)) u_div_ke (
    .clk_i(clk_i), .num_i(sq_b_q), .den_i(rho_b_q), .q_o(ke_q), .neg_o(ke_neg)
  );
  ef2d_div #(.W(W), .F(F)) u_div_u (
    .clk_i(clk_i), .num_i(mx_b_q), .den_i(rho_b_q), .q_o(u_q), .neg_o(u_neg)
  );
  ef2d_div #(.W(W), .F(F)) u_div_v (
    .clk_i(clk_i), .num_i(my_b_q), .den_i(rho_b_q), .q_o(v_q), .neg_o(v_neg)
  );

  // sideband alongside the dividers
  logic [SW-1:0] side_q [QW];
  logic [QW-1:0] vld_s_q;

  always_ff @(posedge clk_i) begin
    side_q[0] <= {e_b_q, mx_b_q, my_b_q, dg_b_q, sat_b_q};
    for (int k = 1; k < QW; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  logic [W-1:0] e_s, mx_s, my_s;
  logic         dg_s, sat_s;

  assign {e_s, mx_s, my_s, dg_s, sat_s} = side_q[QW-1];

  // stage C: clamp quotients, E - ke/2
  logic [W:0]   r_ke, r_u, r_v, r_ds;
  logic [W-1:0] ke_rnd, half;

  assign r_ke   = sat_mag(ke_neg, MW'(ke_q));
  assign r_u    = sat_mag(u_neg, MW'(u_q));
  assign r_v    = sat_mag(v_neg, MW'(v_q));
  assign ke_rnd = r_ke[W-1:0] + W'(r_ke[W-1]);
  assign half   = {ke_rnd[W-1], ke_rnd[W-1:1]};
  assign r_ds   = ssub(e_s, half);

  logic         vld_c_q, dg_c_q, sat_c_q;
  logic [W-1:0] e_c_q, mx_c_q, my_c_q, u_c_q, v_c_q, ds_c_q;

  always_ff @(posedge clk_i) begin
    dg_c_q  <= dg_s;
    sat_c_q <= sat_s | r_ke[W] | r_u[W] | r_v[W] | r_ds[W];
    e_c_q   <= e_s;
    mx_c_q  <= mx_s;
    my_c_q  <= my_s;
    u_c_q   <= r_u[W-1:0];
    v_c_q   <= r_v[W-1:0];
    ds_c_q  <= r_ds[W-1:0];
  end

  // stage D: pressure and velocity products
  logic signed [GW-1:0] gm1;
  logic [GW-1:0]        gm1_mag;
  logic [W-1:0]         p_in;
  logic [GW+W-1:0]      p_pr;
  logic [W:0]           r_p, r_umx, r_mxv, r_myu, r_vmy;

  assign gm1     = GW'(gamma_i) - (GW'(1) << F);
  assign gm1_mag = gm1[GW-1] ? (~gm1 + GW'(1)) : gm1;
  assign p_in    = dg_c_q ? e_c_q : ds_c_q;
  assign p_pr    = (GW+W)'(gm1_mag) * (GW+W)'(mag(p_in));
  assign r_p     = sat_mag(gm1[GW-1] ^ p_in[W-1], MW'(p_pr >> F));
  assign r_umx   = fmul(u_c_q, mx_c_q);
  assign r_mxv   = fmul(mx_c_q, v_c_q);
  assign r_myu   = fmul(my_c_q, u_c_q);
  assign r_vmy   = fmul(v_c_q, my_c_q);

  logic         vld_d_q, dg_d_q, sat_d_q, pfl_d_q;
  logic [W-1:0] e_d_q, mx_d_q, my_d_q, u_d_q, v_d_q, p_d_q;
  logic [W-1:0] umx_d_q, mxv_d_q, myu_d_q, vmy_d_q;

  always_ff @(posedge clk_i) begin
    dg_d_q  <= dg_c_q;
    sat_d_q <= sat_c_q | r_umx[W] | r_mxv[W] | r_myu[W] | r_vmy[W];
    pfl_d_q <= r_p[W];
    e_d_q   <= e_c_q;
    mx_d_q  <= mx_c_q;
    my_d_q  <= my_c_q;
    u_d_q   <= u_c_q;
    v_d_q   <= v_c_q;
    p_d_q   <= r_p[W-1:0];
    umx_d_q <= r_umx[W-1:0];
    mxv_d_q <= r_mxv[W-1:0];
    myu_d_q <= r_myu[W-1:0];
    vmy_d_q <= r_vmy[W-1:0];
  end

  // stage E: E + p and the pressure sums
  logic [W:0] r_ep, r_fxmx, r_fymy;

  assign r_ep   = sadd(e_d_q, p_d_q);
  assign r_fxmx = sadd(umx_d_q, p_d_q);
  assign r_fymy = sadd(vmy_d_q, p_d_q);

  logic         vld_e_q, dg_e_q, sat_e_q, pfl_e_q;
  logic [W-1:0] mx_e_q, my_e_q, u_e_q, v_e_q, p_e_q, ep_e_q;
  logic [W-1:0] fxmx_e_q, mxv_e_q, myu_e_q, fymy_e_q;

  always_ff @(posedge clk_i) begin
    dg_e_q   <= dg_d_q;
    sat_e_q  <= sat_d_q | pfl_d_q | r_ep[W] | r_fxmx[W] | r_fymy[W];
    pfl_e_q  <= pfl_d_q;
    mx_e_q   <= mx_d_q;
    my_e_q   <= my_d_q;
    u_e_q    <= u_d_q;
    v_e_q    <= v_d_q;
    p_e_q    <= p_d_q;
    ep_e_q   <= r_ep[W-1:0];
    fxmx_e_q <= r_fxmx[W-1:0];
    mxv_e_q  <= mxv_d_q;
    myu_e_q  <= myu_d_q;
    fymy_e_q <= r_fymy[W-1:0];
  end

  // stage F: energy fluxes, degenerate select, output registers
  logic [W:0] r_uep, r_vep;

  assign r_uep = fmul(u_e_q, ep_e_q);
  assign r_vep = fmul(v_e_q, ep_e_q);

  logic         done_q, zd_q, sat_q;
  logic [W-1:0] fx_mass_q, fx_mom_x_q, fx_mom_y_q, fx_energy_q;
  logic [W-1:0] fy_mass_q, fy_mom_x_q, fy_mom_y_q, fy_energy_q;

  always_ff @(posedge clk_i) begin
    zd_q        <= dg_e_q;
    sat_q       <= dg_e_q ? pfl_e_q : (sat_e_q | r_uep[W] | r_vep[W]);
    fx_mass_q   <= dg_e_q ? '0 : mx_e_q;
    fx_mom_x_q  <= dg_e_q ? p_e_q : fxmx_e_q;
    fx_mom_y_q  <= dg_e_q ? '0 : mxv_e_q;
    fx_energy_q <= dg_e_q ? '0 : r_uep[W-1:0];
    fy_mass_q   <= dg_e_q ? '0 : my_e_q;
    fy_mom_x_q  <= dg_e_q ? '0 : myu_e_q;
    fy_mom_y_q  <= dg_e_q ? p_e_q : fymy_e_q;
    fy_energy_q <= dg_e_q ? '0 : r_vep[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_s_q <= '0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
      vld_e_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_s_q <= {vld_s_q[QW-2:0], vld_b_q};
      vld_c_q <= vld_s_q[QW-1];
      vld_d_q <= vld_c_q;
      vld_e_q <= vld_d_q;
      done_q  <= vld_e_q;
    end
  end

  assign done_o         = done_q;
  assign zero_density_o = zd_q;
  assign saturated_o    = sat_q;
  assign fx_mass_o      = fx_mass_q;
  assign fx_mom_x_o     = fx_mom_x_q;
  assign fx_mom_y_o     = fx_mom_y_q;
  assign fx_energy_o    = fx_energy_q;
  assign fy_mass_o      = fy_mass_q;
  assign fy_mom_x_o     = fy_mom_x_q;
  assign fy_mom_y_o     = fy_mom_y_q;
  assign fy_energy_o    = fy_energy_q;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && zd_q) |-> (fx_mass_q == '0 && fy_mass_q == '0 && fx_energy_q == '0
                          && fy_energy_q == '0 && fx_mom_y_q == '0 && fy_mom_x_q == '0))
    else $error("degenerate item carries nonzero flux");
  a_degen_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && zd_q) |-> (fx_mom_x_q == fy_mom_y_q))
    else $error("degenerate pressure terms differ");
  a_pipe_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c_q |-> ##3 done_q)
    else $error("item lost in back pipeline");
`endif

endmodule
